/* design/srd_pkg.sv */
// ----------------------------------------------------------------------------
// srd_pkg
// Shared types and constants of the sprite row run-length decoder.
// ----------------------------------------------------------------------------
package srd_pkg;

   // layer limits
   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_HEIGHT = 4096;

   localparam int ROW_W     = 12;
   localparam int POS_W     = 16;
   localparam int LWIDTH_W  = 13;
   localparam int ADDR_W    = 24;
   localparam int WORD_W    = 32;
   localparam int REMAIN_W  = 7;

   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 88;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [POS_W-1:0]    TRANSPARENT_EDGE = 16'hFFFF;
   localparam logic [POS_W-1:0]    POS_MAX          = 16'hFFFF;
   localparam logic [LWIDTH_W-1:0] LWIDTH_RESET     = 13'd1;

   // item kinds on the request side
   localparam logic FUNC_BEGIN_ROW = 1'b0;
   localparam logic FUNC_STREAM    = 1'b1;

   // result kinds
   localparam logic KIND_PIXEL   = 1'b0;
   localparam logic KIND_ROW_END = 1'b1;

   // command ops
   localparam logic [1:0] OP_SKIP   = 2'd0;
   localparam logic [1:0] OP_COPY   = 2'd1;
   localparam logic [1:0] OP_PLAYER = 2'd2;
   localparam logic [1:0] OP_END    = 2'd3;

   // register index
   localparam logic REG_LAYER_WIDTH = 1'b0;

   typedef struct packed {
      logic                func;
      logic [ROW_W-1:0]    row_number;
      logic [POS_W-1:0]    left_edge;
      logic                no_commands;
      logic [WORD_W-1:0]   stream_word;
   } item_type;

   typedef struct packed {
      logic                kind;
      logic [ADDR_W-1:0]   address;
      logic [POS_W-1:0]    pos_x;
      logic [ROW_W-1:0]    pos_y;
      logic [WORD_W-1:0]   pixel_colour;
      logic                player_color;
      logic                out_of_range;
   } result_type;

endpackage

/* design/srd_csr.sv */
// ----------------------------------------------------------------------------
// srd_csr
// Register port holding the layer width.
// ----------------------------------------------------------------------------
module srd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [srd_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [srd_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [srd_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready,
   output logic [srd_pkg::LWIDTH_W-1:0]        layer_width
);

   logic [srd_pkg::LWIDTH_W-1:0] layer_width_ff;
   logic [srd_pkg::LWIDTH_W-1:0] layer_width_in;
   logic                         sel_width;

   // register index is the word address
   assign sel_width  = (csr_paddr[2] == srd_pkg::REG_LAYER_WIDTH);
   assign csr_pready = 1'b1;

   always_comb begin
      layer_width_in = layer_width_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && sel_width) begin
         layer_width_in = csr_pwdata[srd_pkg::LWIDTH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         layer_width_ff <= srd_pkg::LWIDTH_RESET;
      end else begin
         layer_width_ff <= layer_width_in;
      end
   end

   assign csr_prdata  = sel_width
                      ? {{(srd_pkg::CSR_DATA_W-srd_pkg::LWIDTH_W){1'b0}}, layer_width_ff}
                      : '0;
   assign layer_width = layer_width_ff;

endmodule

/* design/srd_in_stage.sv */
// ----------------------------------------------------------------------------
// srd_in_stage
// Input register: unpacks and holds one request word for the decoder.
// ----------------------------------------------------------------------------
module srd_in_stage (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata: row_number, left_edge, no_commands, stream_word (low bit up)
   input  logic [srd_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // tuser: func
   input  logic                                req_tuser,
   input  logic                                advance,
   output logic                                item_valid,
   output srd_pkg::item_type                   item
);

   logic              valid_ff;
   logic              valid_in;
   srd_pkg::item_type item_ff;
   logic              take;

   assign req_tready = !valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.func        <= req_tuser;
         item_ff.row_number  <= req_tdata[11:0];
         item_ff.left_edge   <= req_tdata[27:12];
         item_ff.no_commands <= req_tdata[28];
         item_ff.stream_word <= req_tdata[60:29];
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

/* design/srd_decode.sv */
// ----------------------------------------------------------------------------
// srd_decode
// Row state and command decode; forms at most one result per item.
// ----------------------------------------------------------------------------
module srd_decode (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                item_valid,
   input  srd_pkg::item_type                   item,
   input  logic                                advance,
   input  logic [srd_pkg::LWIDTH_W-1:0]        layer_width,
   output logic                                has_result,
   output srd_pkg::result_type                 result
);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_CMD,
      PH_COPY
   } phase_type;

   phase_type                      phase_ff, phase_in;
   logic [srd_pkg::ROW_W-1:0]      row_ff, row_in;
   logic [srd_pkg::POS_W-1:0]      pos_ff, pos_in;
   logic [srd_pkg::REMAIN_W-1:0]   remain_ff, remain_in;
   logic                           player_ff, player_in;

   logic [1:0]                     op;
   logic [srd_pkg::REMAIN_W-1:0]   count;
   logic [srd_pkg::POS_W:0]        skip_sum;
   logic [srd_pkg::POS_W:0]        step_sum;
   logic [srd_pkg::POS_W-1:0]      pos_skip;
   logic [srd_pkg::POS_W-1:0]      pos_step;
   logic [srd_pkg::REMAIN_W-1:0]   remain_dec;
   logic [16:0]                    lw_ext;
   logic [16:0]                    eff_ext;
   logic [srd_pkg::LWIDTH_W-1:0]   eff_w;
   logic [24:0]                    row_base;
   logic [srd_pkg::ADDR_W-1:0]     pixel_addr;
   logic                           oor;

   assign op    = item.stream_word[1:0];
   assign count = {1'b0, item.stream_word[7:2]} + 7'd1;

   // saturating position updates
   assign skip_sum = {1'b0, pos_ff} + 17'(count);
   assign step_sum = {1'b0, pos_ff} + 17'd1;
   assign pos_skip = skip_sum[srd_pkg::POS_W] ? srd_pkg::POS_MAX : skip_sum[15:0];
   assign pos_step = step_sum[srd_pkg::POS_W] ? srd_pkg::POS_MAX : step_sum[15:0];
   assign remain_dec = remain_ff - 7'd1;

   // width clamp, linear address and bounds
   assign lw_ext  = 17'(layer_width);
   assign eff_ext = (lw_ext > 17'(srd_pkg::MAX_WIDTH)) ? 17'(srd_pkg::MAX_WIDTH) : lw_ext;
   assign eff_w   = eff_ext[srd_pkg::LWIDTH_W-1:0];
   assign row_base   = 25'(row_ff) * 25'(eff_w);
   assign pixel_addr = row_base[srd_pkg::ADDR_W-1:0] + 24'(pos_ff);
   assign oor = (pos_ff >= 16'(eff_w)) || (32'(row_ff) >= 32'(srd_pkg::MAX_HEIGHT));

   always_comb begin
      phase_in   = phase_ff;
      row_in     = row_ff;
      pos_in     = pos_ff;
      remain_in  = remain_ff;
      player_in  = player_ff;
      has_result = 1'b0;
      result     = '0;

      if (item_valid) begin
         if (item.func == srd_pkg::FUNC_BEGIN_ROW) begin
            row_in    = item.row_number;
            remain_in = '0;
            player_in = 1'b0;
            if (item.left_edge == srd_pkg::TRANSPARENT_EDGE || item.no_commands) begin
               phase_in = PH_IDLE;
            end else begin
               pos_in   = item.left_edge;
               phase_in = PH_CMD;
            end
         end else begin
            case (phase_ff)
               PH_CMD: begin
                  case (op)
                     srd_pkg::OP_END: begin
                        has_result   = 1'b1;
                        result.kind  = srd_pkg::KIND_ROW_END;
                        result.pos_x = pos_ff;
                        result.pos_y = row_ff;
                        phase_in     = PH_IDLE;
                     end
                     srd_pkg::OP_SKIP: begin
                        pos_in = pos_skip;
                     end
                     default: begin
                        remain_in = count;
                        player_in = (op == srd_pkg::OP_PLAYER);
                        phase_in  = PH_COPY;
                     end
                  endcase
               end
               PH_COPY: begin
                  has_result          = 1'b1;
                  result.kind         = srd_pkg::KIND_PIXEL;
                  result.address      = pixel_addr;
                  result.pos_x        = pos_ff;
                  result.pos_y        = row_ff;
                  result.pixel_colour = item.stream_word;
                  result.player_color = player_ff;
                  result.out_of_range = oor;
                  pos_in              = pos_step;
                  remain_in           = remain_dec;
                  if (remain_dec == '0) begin
                     phase_in = PH_CMD;
                  end
               end
               default: begin
                  // idle: stream words are dropped
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         row_ff    <= '0;
         pos_ff    <= '0;
         remain_ff <= '0;
         player_ff <= 1'b0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         row_ff    <= row_in;
         pos_ff    <= pos_in;
         remain_ff <= remain_in;
         player_ff <= player_in;
      end
   end

endmodule

/* design/srd_out_stage.sv */
// ----------------------------------------------------------------------------
// srd_out_stage
// Result register driving the response channel.
// ----------------------------------------------------------------------------
module srd_out_stage (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load,
   input  srd_pkg::result_type                 result,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata: address, pos_x, pos_y, pixel_colour, player_color, out_of_range
   output logic [srd_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // tuser: kind
   output logic                                rsp_tuser,
   output logic                                room
);

   logic                valid_ff;
   logic                valid_in;
   srd_pkg::result_type result_ff;

   assign room = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = result_ff.kind;
   assign rsp_tdata  = {2'b00,
                        result_ff.out_of_range,
                        result_ff.player_color,
                        result_ff.pixel_colour,
                        result_ff.pos_y,
                        result_ff.pos_x,
                        result_ff.address};

endmodule

/* design/sprite_row_rle_decoder.sv */
// ----------------------------------------------------------------------------
// sprite_row_rle_decoder
// Decodes run-length row commands of a sprite layer into pixel writes.
// ----------------------------------------------------------------------------
// usage
//   req channel: tuser selects a begin-row word (0) or a stream word (1);
//   a begin-row word carries row, left edge and the empty-row flag, stream
//   words carry command bytes and colour words.
//   rsp channel: tuser 0 is a pixel write with its linear address, tuser 1
//   marks the end of a row with its final position.
//   csr port: one register, layer_width at byte address 0; write it only
//   while no word is in flight.
// timing
//   one word is taken every cycle while the result side does not stall; a
//   result moves from the input register, where its word is taken, to the
//   result register that drives rsp.
//   the address path is one 12x13 multiply and a 24-bit add per word.
// reset and stall
//   reset empties both registers, drops the current row and sets the layer
//   width to 1. while rsp is stalled, words that give no result still pass;
//   a word that gives a result waits in the input register and req_tready
//   falls until the result register frees up.
// ----------------------------------------------------------------------------
module sprite_row_rle_decoder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata: row_number, left_edge, no_commands, stream_word (low bit up)
   input  logic [srd_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // tuser: func
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata: address, pos_x, pos_y, pixel_colour, player_color, out_of_range
   output logic [srd_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // tuser: kind
   output logic                                rsp_tuser,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [srd_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [srd_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [srd_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   logic [srd_pkg::LWIDTH_W-1:0] layer_width;
   logic                         item_valid;
   srd_pkg::item_type            item;
   logic                         has_result;
   srd_pkg::result_type          result;
   logic                         room;
   logic                         advance;
   logic                         load;

   // a word moves on unless its result would land on a full output register
   assign advance = item_valid && (!has_result || room);
   assign load    = advance && has_result;

   srd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .layer_width (layer_width)
   );

   srd_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   srd_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (item_valid),
      .item        (item),
      .advance     (advance),
      .layer_width (layer_width),
      .has_result  (has_result),
      .result      (result)
   );

   srd_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .result     (result),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .room       (room)
   );

   // an empty input register always takes a word
   assert property (@(posedge clock) disable iff (reset)
      !item_valid |-> req_tready)
      else $error("input register empty but req_tready low");

   // a word held back stays put until it can move on
   assert property (@(posedge clock) disable iff (reset)
      item_valid && !advance |=> item_valid && $stable(item))
      else $error("held word lost or changed");

   // a stalled result is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !load)
      else $error("result register overwritten while stalled");

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sprite row run-length decoder: directed rows
// cover the corner cases, then random rows are run under several layer widths,
// with random idling on both streams and one long stall of the result side.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RESET_CYCLES = 9;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT = 500000;
   localparam int ROWS_PER_WIDTH = 70;

   typedef enum logic [1:0] {ROW_IDLE, ROW_CMD, ROW_COPY} row_phase_type;

   // request tdata layout, lowest field last
   typedef struct packed {
      logic [2:0]                   pad;
      logic [srd_pkg::WORD_W-1:0]   stream_word;
      logic                         no_commands;
      logic [srd_pkg::POS_W-1:0]    left_edge;
      logic [srd_pkg::ROW_W-1:0]    row_number;
   } req_fields_type;

   // result tdata layout, lowest field last
   typedef struct packed {
      logic [1:0]                   pad;
      logic                         out_of_range;
      logic                         player_color;
      logic [srd_pkg::WORD_W-1:0]   pixel_colour;
      logic [srd_pkg::ROW_W-1:0]    pos_y;
      logic [srd_pkg::POS_W-1:0]    pos_x;
      logic [srd_pkg::ADDR_W-1:0]   address;
   } rsp_fields_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [srd_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic                            req_tuser = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [srd_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                            rsp_tuser;
   logic                            csr_psel = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite = 1'b0;
   logic [srd_pkg::CSR_ADDR_W-1:0]  csr_paddr = '0;
   logic [srd_pkg::CSR_DATA_W-1:0]  csr_pwdata = '0;
   logic [srd_pkg::CSR_DATA_W-1:0]  csr_prdata;
   logic                            csr_pready;

   sprite_row_rle_decoder dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // decoder state as the bench sees it
   row_phase_type                   row_phase = ROW_IDLE;
   logic [srd_pkg::ROW_W-1:0]       row_now = '0;
   logic [srd_pkg::POS_W-1:0]       pos_now = '0;
   logic [srd_pkg::REMAIN_W-1:0]    run_left = '0;
   logic                            run_is_player = 1'b0;
   logic [srd_pkg::LWIDTH_W-1:0]    width_now = srd_pkg::LWIDTH_RESET;

   srd_pkg::result_type             pixel_events_due[$];
   int                              mismatches = 0;
   int                              words_sent = 0;
   int                              cycles = 0;
   bit                              quiet = 1'b0;
   bit                              hold_request = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic logic [srd_pkg::POS_W-1:0] sat_step(
         input logic [srd_pkg::POS_W-1:0] a,
         input logic [srd_pkg::REMAIN_W-1:0] b);
      logic [srd_pkg::POS_W:0] s;
      s = {1'b0, a} + (srd_pkg::POS_W+1)'(b);
      return s[srd_pkg::POS_W] ? srd_pkg::POS_MAX : s[srd_pkg::POS_W-1:0];
   endfunction

   // works out what one accepted word should produce
   function automatic void decode_word(input logic func, input req_fields_type f);
      srd_pkg::result_type r;
      logic [1:0] op;
      logic [srd_pkg::REMAIN_W-1:0] cnt;
      logic [srd_pkg::LWIDTH_W-1:0] w;
      logic [31:0] lin;
      r = '0;
      if (func == srd_pkg::FUNC_BEGIN_ROW) begin
         row_now = f.row_number;
         run_left = '0;
         run_is_player = 1'b0;
         if (f.left_edge == srd_pkg::TRANSPARENT_EDGE || f.no_commands) begin
            row_phase = ROW_IDLE;
         end else begin
            pos_now = f.left_edge;
            row_phase = ROW_CMD;
         end
      end else if (row_phase == ROW_CMD) begin
         op = f.stream_word[1:0];
         cnt = srd_pkg::REMAIN_W'(f.stream_word[7:2]) + srd_pkg::REMAIN_W'(1);
         if (op == srd_pkg::OP_END) begin
            r.kind = srd_pkg::KIND_ROW_END;
            r.pos_x = pos_now;
            r.pos_y = row_now;
            pixel_events_due.push_back(r);
            row_phase = ROW_IDLE;
         end else if (op == srd_pkg::OP_SKIP) begin
            pos_now = sat_step(pos_now, cnt);
         end else begin
            run_left = cnt;
            run_is_player = (op == srd_pkg::OP_PLAYER);
            row_phase = ROW_COPY;
         end
      end else if (row_phase == ROW_COPY) begin
         w = (width_now > srd_pkg::LWIDTH_W'(srd_pkg::MAX_WIDTH))
           ? srd_pkg::LWIDTH_W'(srd_pkg::MAX_WIDTH) : width_now;
         lin = 32'(row_now) * 32'(w) + 32'(pos_now);
         r.kind = srd_pkg::KIND_PIXEL;
         r.address = lin[srd_pkg::ADDR_W-1:0];
         r.pos_x = pos_now;
         r.pos_y = row_now;
         r.pixel_colour = f.stream_word;
         r.player_color = run_is_player;
         r.out_of_range = (32'(pos_now) >= 32'(w)) ||
                          (32'(row_now) >= 32'(srd_pkg::MAX_HEIGHT));
         pixel_events_due.push_back(r);
         pos_now = sat_step(pos_now, srd_pkg::REMAIN_W'(1));
         run_left = run_left - srd_pkg::REMAIN_W'(1);
         if (run_left == '0)
            row_phase = ROW_CMD;
      end
   endfunction

   // result side: checks every word taken off rsp
   always @(posedge clock) begin
      srd_pkg::result_type got;
      srd_pkg::result_type want;
      rsp_fields_type d;
      if (!reset && rsp_tvalid && rsp_tready) begin
         d = rsp_tdata;
         got.kind = rsp_tuser;
         got.address = d.address;
         got.pos_x = d.pos_x;
         got.pos_y = d.pos_y;
         got.pixel_colour = d.pixel_colour;
         got.player_color = d.player_color;
         got.out_of_range = d.out_of_range;
         if (pixel_events_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("[%0t] unexpected result %p", $realtime, got);
         end else begin
            want = pixel_events_due.pop_front();
            if (got.kind !== want.kind || got.address !== want.address ||
                got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
                got.pixel_colour !== want.pixel_colour ||
                got.player_color !== want.player_color ||
                got.out_of_range !== want.out_of_range) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("[%0t] mismatch: expected %p, got %p", $realtime, want, got);
            end
         end
      end
   end

   function automatic int pick_gap();
      int r;
      if (quiet)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // result side ready: random stalls, or one long hold-off on request
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else if (quiet) begin
            rsp_tready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   task automatic send_item(input logic func, input req_fields_type f);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tdata <= f;
      do @(posedge clock); while (!req_tready);
      decode_word(func, f);
      words_sent++;
   endtask

   task automatic begin_row(input logic [srd_pkg::ROW_W-1:0] row,
                            input logic [srd_pkg::POS_W-1:0] left,
                            input logic empty);
      req_fields_type f;
      f = {$urandom(), $urandom()};
      f.pad = '0;
      f.row_number = row;
      f.left_edge = left;
      f.no_commands = empty;
      send_item(srd_pkg::FUNC_BEGIN_ROW, f);
   endtask

   task automatic stream_word(input logic [srd_pkg::WORD_W-1:0] w);
      req_fields_type f;
      f = {$urandom(), $urandom()};
      f.pad = '0;
      f.stream_word = w;
      send_item(srd_pkg::FUNC_STREAM, f);
   endtask

   // command byte with random upper bits, which the decoder ignores
   function automatic logic [srd_pkg::WORD_W-1:0] cmd(input logic [1:0] op,
                                                      input logic [5:0] count);
      return {24'($urandom()), count, op};
   endfunction

   task automatic settle();
      req_tvalid <= 1'b0;
      while (pixel_events_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_layer_width(input logic [srd_pkg::LWIDTH_W-1:0] w);
      settle();
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= srd_pkg::CSR_ADDR_W'(4 * srd_pkg::REG_LAYER_WIDTH);
      csr_pwdata <= srd_pkg::CSR_DATA_W'(w);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      width_now = w;
   endtask

   task automatic test_reset_width();
      begin_row(12'd3, 16'd0, 1'b0);
      stream_word(cmd(srd_pkg::OP_COPY, 6'd1));
      stream_word($urandom());
      stream_word($urandom());
      stream_word(cmd(srd_pkg::OP_END, 6'd0));
   endtask

   task automatic test_directed();
      set_layer_width(13'd16);
      // stream with no row open
      stream_word($urandom());
      // transparent row, then an empty row: stream ignored
      begin_row(12'd0, srd_pkg::TRANSPARENT_EDGE, 1'b0);
      stream_word(cmd(srd_pkg::OP_COPY, 6'd0));
      stream_word(32'hFFFF_FFFF);
      begin_row(12'd5, 16'd2, 1'b1);
      stream_word(cmd(srd_pkg::OP_END, 6'd0));
      // last row, every op
      begin_row(12'd4095, 16'd0, 1'b0);
      stream_word(cmd(srd_pkg::OP_SKIP, 6'd2));
      stream_word(cmd(srd_pkg::OP_COPY, 6'd0));
      stream_word(32'hFFFF_FFFF);
      stream_word(cmd(srd_pkg::OP_PLAYER, 6'd1));
      stream_word(32'h0000_0000);
      stream_word(32'hA5A5_5A5A);
      stream_word(cmd(srd_pkg::OP_END, 6'd63));
      // row dropped mid-run by a new begin-row
      begin_row(12'd7, 16'd10, 1'b0);
      stream_word(cmd(srd_pkg::OP_COPY, 6'd3));
      stream_word($urandom());
      begin_row(12'd8, 16'd14, 1'b0);
      stream_word(cmd(srd_pkg::OP_END, 6'd0));
      // position saturates at the top of the range
      begin_row(12'd1, 16'hFFF0, 1'b0);
      stream_word(cmd(srd_pkg::OP_SKIP, 6'd63));
      stream_word(cmd(srd_pkg::OP_PLAYER, 6'd1));
      stream_word($urandom());
      stream_word($urandom());
      stream_word(cmd(srd_pkg::OP_END, 6'd0));
   endtask

   // mostly well-formed rows with random content, some noise and broken rows
   task automatic random_rows(input int n);
      int stop_at;
      int r;
      int k;
      int runs;
      logic [1:0] op;
      logic [5:0] count;
      logic [srd_pkg::POS_W-1:0] left;
      stop_at = words_sent + n;
      while (words_sent < stop_at) begin
         r = $urandom_range(0, 99);
         if (r < 8) begin
            stream_word($urandom());
         end else if (r < 15) begin
            if ($urandom_range(0, 1))
               begin_row(srd_pkg::ROW_W'($urandom()), srd_pkg::TRANSPARENT_EDGE,
                         1'($urandom()));
            else
               begin_row(srd_pkg::ROW_W'($urandom()), srd_pkg::POS_W'($urandom()), 1'b1);
            repeat ($urandom_range(0, 3)) stream_word($urandom());
         end else begin
            k = $urandom_range(0, 9);
            if (k < 7)
               left = srd_pkg::POS_W'($urandom_range(0, 32'(width_now) + 8));
            else if (k < 9)
               left = srd_pkg::POS_W'($urandom_range(0, 16'hFFFE));
            else
               left = srd_pkg::POS_W'($urandom_range(16'hFFE0, 16'hFFFE));
            begin_row(srd_pkg::ROW_W'($urandom()), left, 1'b0);
            runs = $urandom_range(1, 5);
            for (int i = 0; i < runs; i++) begin
               op = 2'($urandom_range(0, 2));
               count = ($urandom_range(0, 9) == 0) ? 6'($urandom())
                                                   : 6'($urandom_range(0, 5));
               stream_word(cmd(op, count));
               if (op != srd_pkg::OP_SKIP) begin
                  k = 32'(count) + 1;
                  // now and then the row is cut short inside a run
                  if ($urandom_range(0, 19) == 0)
                     k = $urandom_range(0, k - 1);
                  repeat (k) stream_word($urandom());
               end
            end
            if ($urandom_range(0, 9) != 0)
               stream_word(cmd(srd_pkg::OP_END, 6'($urandom())));
         end
      end
   endtask

   task automatic test_widths();
      logic [srd_pkg::LWIDTH_W-1:0] widths[6];
      widths = '{13'd0, 13'd4096, 13'd8191, 13'd1,
                 srd_pkg::LWIDTH_W'($urandom_range(2, 4095)),
                 srd_pkg::LWIDTH_W'($urandom())};
      foreach (widths[i]) begin
         set_layer_width(widths[i]);
         // one phase runs with no idling at all
         quiet = (i == 2);
         random_rows(ROWS_PER_WIDTH);
         quiet = 1'b0;
      end
   endtask

   task automatic test_backpressure();
      set_layer_width(srd_pkg::LWIDTH_W'($urandom_range(64, 512)));
      quiet = 1'b1;
      hold_request = 1'b1;
      begin_row(srd_pkg::ROW_W'($urandom()), 16'd0, 1'b0);
      stream_word(cmd(srd_pkg::OP_PLAYER, 6'd63));
      repeat (64) stream_word($urandom());
      stream_word(cmd(srd_pkg::OP_END, 6'd0));
      quiet = 1'b0;
      random_rows(20);
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_width();
      test_directed();
      test_widths();
      test_backpressure();
      settle();
      mismatches += pixel_events_due.size();
      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
